[src/qtlj_pkg.sv]
`timescale 1ns / 1ps
// Package for the quoted text line joiner: character codes, join phase type
// and configuration register indexes. No dependencies.
package qtlj_pkg;

    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_ESCAPES = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_SKIP   = 8'd1;

    typedef enum logic [1:0] {
        PH_NORMAL    = 2'd0,
        PH_SKIP_LEAD = 2'd1,
        PH_SKIP_TAIL = 2'd2,
        PH_START     = 2'd3
    } join_phase_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c inside {CH_SP, CH_TAB, CH_VT, CH_LF};
    endfunction

endpackage

[src/quoted_text_line_joiner_unit.sv]
`timescale 1ns / 1ps
// Top level of the quoted text line joiner: input register, filter logic and
// result register. Depends on qtlj_pkg.

// The block takes one character transaction per clock cycle while the output
// side does not stall, and gives zero or one result per transaction, which
// passes through the input register and then the result register. The escape
// flag and the join phase are updated from the registered input byte, and that
// state loop sets the rate of one byte per cycle. An end transaction gives an
// end marker with char_out zero and returns the filters to the string start.
// The result register and the input register let a new byte be taken while a
// result waits. Configuration writes are always ready and are meant to happen
// only while the block is idle.
module quoted_text_line_joiner_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [qtlj_pkg::CHAR_W-1:0]   char_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [qtlj_pkg::CHAR_W-1:0]   char_out,
    output logic                          end_of_string,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qtlj_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [qtlj_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qtlj_pkg::*;

    logic              strip_escapes_reg;
    logic              marker_skip_reg;
    logic              escape_pending_reg;
    logic              escape_pending_next;
    join_phase_t       join_phase_reg;
    join_phase_t       join_phase_next;

    logic              s1_valid_reg;
    logic              s1_command_reg;
    logic [CHAR_W-1:0] s1_char_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_out_reg;
    logic              end_reg;

    logic              advance;
    logic              emit;
    logic              pass;
    logic [CHAR_W-1:0] res_char;
    logic              res_end;
    join_phase_t       phase_eff;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign char_out      = char_out_reg;
    assign end_of_string = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_escapes_reg <= 1'b0;
            marker_skip_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_STRIP_ESCAPES)
                strip_escapes_reg <= cfg_data[0];
            else if (cfg_index == CFG_MARKER_SKIP)
                marker_skip_reg <= cfg_data[0];
        end
    end

    // Filter chain on the registered byte; state moves only when the byte
    // leaves the input register.
    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        join_phase_next     = join_phase_reg;
        emit                = 1'b0;
        pass                = 1'b0;
        res_char            = s1_char_reg;
        res_end             = 1'b0;
        phase_eff           = join_phase_reg;
        if (join_phase_reg == PH_START)
            phase_eff = marker_skip_reg ? PH_SKIP_LEAD : PH_NORMAL;

        if (s1_valid_reg && advance)
        begin
            if (s1_command_reg)
            begin
                escape_pending_next = 1'b0;
                join_phase_next     = PH_START;
                emit                = 1'b1;
                res_char            = '0;
                res_end             = 1'b1;
            end
            else if (s1_char_reg != CH_CR)
            begin
                pass                = 1'b1;
                escape_pending_next = 1'b0;
                if (strip_escapes_reg)
                begin
                    if (s1_char_reg == CH_BS && !escape_pending_reg)
                    begin
                        escape_pending_next = 1'b1;
                        pass                = 1'b0;
                    end
                    else if (s1_char_reg == CH_LF && escape_pending_reg)
                    begin
                        pass = 1'b0;
                    end
                end

                if (pass)
                begin
                    case (phase_eff)
                        PH_NORMAL:
                        begin
                            emit = 1'b1;
                            if (s1_char_reg == CH_LF)
                            begin
                                join_phase_next = PH_SKIP_LEAD;
                                res_char        = CH_SP;
                            end
                            else
                            begin
                                join_phase_next = PH_NORMAL;
                            end
                        end
                        default:
                        begin
                            if (is_space(s1_char_reg))
                            begin
                                join_phase_next = phase_eff;
                            end
                            else if (phase_eff == PH_SKIP_LEAD && marker_skip_reg)
                            begin
                                // The marker character itself is dropped.
                                join_phase_next = PH_SKIP_TAIL;
                            end
                            else
                            begin
                                join_phase_next = PH_NORMAL;
                                emit            = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            join_phase_reg     <= PH_START;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
            join_phase_reg     <= join_phase_next;
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_command_reg <= command;
            s1_char_reg    <= char_in;
        end
        if (advance && emit)
        begin
            char_out_reg <= res_char;
            end_reg      <= res_end;
        end
    end

endmodule

[src/qtlj_checker.sv]
`timescale 1ns / 1ps
// Port checker for the quoted text line joiner and its bind statement.
// Depends on qtlj_pkg and quoted_text_line_joiner_unit.
module qtlj_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [qtlj_pkg::CHAR_W-1:0]   char_out,
    input logic                          end_of_string,
    input logic                          cfg_ready
);
    import qtlj_pkg::*;

    // An end marker always carries a zero character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> char_out == '0)
    else $error("end marker with nonzero char_out");

    // The input side is held back only while a result waits at a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out)
            && $stable(end_of_string))
    else $error("stalled result changed");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("configuration port not ready");

endmodule

bind quoted_text_line_joiner_unit qtlj_checker u_qtlj_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_out      (char_out),
    .end_of_string (end_of_string),
    .cfg_ready     (cfg_ready)
);

[test/qtlj_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the quoted text line joiner testbench: a bit-accurate
// prediction of the joined character stream and the check of each result.
// Depends on qtlj_pkg for character codes, register indexes and the phase type.
package qtlj_tb_pkg;

    import qtlj_pkg::*;

    class line_join_scoreboard;

        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              eos;
        } joined_char_t;

        logic        strip_escapes;
        logic        marker_skip;
        logic        backslash_seen;
        join_phase_t phase;

        joined_char_t joined_queue[$];
        int           mismatches;
        int           results_checked;
        int           ends_checked;

        function new();
            strip_escapes   = 1'b0;
            marker_skip     = 1'b0;
            backslash_seen  = 1'b0;
            phase           = PH_START;
            mismatches      = 0;
            results_checked = 0;
            ends_checked    = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == CFG_STRIP_ESCAPES)
                strip_escapes = data[0];
            else if (index == CFG_MARKER_SKIP)
                marker_skip = data[0];
        endfunction

        function bit is_blank(logic [CHAR_W-1:0] ch);
            return ch == CH_SP || ch == CH_TAB || ch == CH_VT || ch == CH_LF;
        endfunction

        // Runs one accepted transaction through the three filters and queues
        // the character or end marker that it produces, if any.
        function void predict_joined(logic cmd, logic [CHAR_W-1:0] ch);
            join_phase_t  eff;
            joined_char_t item;
            if (cmd)
            begin
                backslash_seen = 1'b0;
                phase = PH_START;
                item.ch = '0;
                item.eos = 1'b1;
                joined_queue.push_back(item);
                return;
            end
            if (ch == CH_CR)
                return;
            if (strip_escapes)
            begin
                if (ch == CH_BS && !backslash_seen)
                begin
                    backslash_seen = 1'b1;
                    return;
                end
                if (ch == CH_LF && backslash_seen)
                begin
                    backslash_seen = 1'b0;
                    return;
                end
            end
            backslash_seen = 1'b0;

            // The string start resolves with the marker setting of its first byte.
            eff = phase;
            if (eff == PH_START)
                eff = marker_skip ? PH_SKIP_LEAD : PH_NORMAL;

            item.eos = 1'b0;
            if (eff == PH_NORMAL)
            begin
                phase = (ch == CH_LF) ? PH_SKIP_LEAD : PH_NORMAL;
                item.ch = (ch == CH_LF) ? CH_SP : ch;
                joined_queue.push_back(item);
                return;
            end
            if (is_blank(ch))
            begin
                phase = eff;
                return;
            end
            if (eff == PH_SKIP_LEAD && marker_skip)
            begin
                phase = PH_SKIP_TAIL;
                return;
            end
            phase = PH_NORMAL;
            item.ch = ch;
            joined_queue.push_back(item);
        endfunction

        function void check_joined(logic [CHAR_W-1:0] ch, logic eos);
            joined_char_t want;
            if (joined_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result char_out=%02h end_of_string=%0b",
                             $time, ch, eos);
                return;
            end
            want = joined_queue.pop_front();
            results_checked++;
            if (eos === 1'b1)
                ends_checked++;
            if (ch !== want.ch || eos !== want.eos)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch char_out exp %02h got %02h,",
                              " end_of_string exp %0b got %0b"},
                             $time, want.ch, ch, want.eos, eos);
            end
        endfunction

        function int pending();
            return joined_queue.size();
        endfunction

    endclass

endpackage

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for quoted_text_line_joiner_unit: directed and random strings
// under all register settings, with random gaps and stalls on both channels.
// Depends on qtlj_pkg and qtlj_tb_pkg.
module tb_top;

    import qtlj_pkg::*;
    import qtlj_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 240;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   command = 1'b0;
    logic [CHAR_W-1:0]      char_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [CHAR_W-1:0]      char_out;
    logic                   end_of_string;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    line_join_scoreboard board = new();

    int cycle_count = 0;
    int items_sent = 0;
    int stall_left = 0;
    bit quiet_mode = 1'b0;

    quoted_text_line_joiner_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .char_in       (char_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_out      (char_out),
        .end_of_string (end_of_string),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none at all in quiet stretches.
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(20, 4);
    endfunction

    // Results are sampled with the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_joined(char_out, end_of_string);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    out_stall <= 1'b1;
                    stall_left--;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // Called at a clock edge; returns at the edge where the transaction was
    // taken, or after the idle gap that follows it.
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch);
        int gap;
        in_valid <= 1'b1;
        command  <= cmd;
        char_in  <= ch;
        do @(posedge clk); while (in_stall);
        board.predict_joined(cmd, ch);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_item(1'b0, ch);
    endtask

    task automatic send_end();
        send_item(1'b1, CHAR_W'($urandom_range(255)));
    endtask

    // The block may still hold a transaction that gives no result, so a few
    // extra cycles pass once every expected result has arrived.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic strip, input logic comment);
        logic [CFG_INDEX_W-1:0] idx [3];
        logic [CFG_DATA_W-1:0]  val [3];
        int n;
        idx[0] = CFG_STRIP_ESCAPES;
        val[0] = strip;
        idx[1] = CFG_MARKER_SKIP;
        val[1] = comment;
        idx[2] = CFG_INDEX_W'($urandom_range(255, CFG_MARKER_SKIP + 1));
        val[2] = CFG_DATA_W'($urandom_range(1));
        n = $urandom_range(3, 2);
        wait_idle();
        for (int k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            board.write_register(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_blank();
        case ($urandom_range(5))
            0, 1:    return CH_SP;
            2, 3:    return CH_TAB;
            4:       return CH_VT;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(11))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_VT;
            3:       return CH_LF;
            4:       return CH_CR;
            5:       return CH_BS;
            default: return CHAR_W'($urandom_range(255));
        endcase
    endfunction

    // A string of one to four marked lines with assorted line breaks.
    task automatic send_marked_string();
        int lines;
        lines = $urandom_range(4, 1);
        repeat (lines)
        begin
            repeat ($urandom_range(2)) send_char(pick_blank());
            send_char(CHAR_W'($urandom_range(255)));
            repeat ($urandom_range(2)) send_char(pick_blank());
            repeat ($urandom_range(8)) send_char(pick_char());
            case ($urandom_range(3))
                0:
                begin
                    send_char(CH_LF);
                end
                1:
                begin
                    send_char(CH_CR);
                    send_char(CH_LF);
                end
                2:
                begin
                    send_char(CH_BS);
                    send_char(CH_LF);
                end
                default:
                begin
                    send_char(CH_BS);
                    send_char(CH_CR);
                    send_char(CH_LF);
                end
            endcase
        end
        send_end();
    endtask

    task automatic send_loose_string();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (len) send_char(pick_char());
        send_end();
    endtask

    initial
    begin
        int mode;
        int phase_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: extremes of the byte, every blank, a carriage
        // return and line feed pair, and a backslash passed unchanged.
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_SP);
        send_char(CH_TAB);
        send_char(CH_VT);
        send_char(8'h78);
        send_char(CH_BS);
        send_char(CH_LF);
        send_char(8'h79);
        send_end();

        // Escapes on: an escaped backslash is kept, an escaped line feed
        // vanishes, and a backslash left pending at the end is lost.
        set_mode(1'b1, 1'b0);
        send_char(CH_BS);
        send_char(CH_BS);
        send_char(CH_BS);
        send_char(CH_LF);
        send_char(8'h7A);
        send_char(CH_BS);
        send_end();
        send_char(8'h71);

        // Comment mode switched on in the middle of a string.
        set_mode(1'b1, 1'b1);
        send_char(CH_LF);
        send_char(CH_SP);
        send_char(8'h23);
        send_char(CH_TAB);
        send_char(8'h63);
        send_end();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            mode = (p < 4) ? p : $urandom_range(3);
            set_mode(mode[0], mode[1]);
            quiet_mode = ($urandom_range(3) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:    send_marked_string();
                    4, 5, 6, 7, 8: send_loose_string();
                    default:
                    begin
                        repeat ($urandom_range(6, 1))
                            send_item(1'($urandom_range(1)),
                                      CHAR_W'($urandom_range(255)));
                    end
                endcase
            end
        end

        quiet_mode = 1'b0;
        wait_idle();
        $display("tb_top: %0d transactions sent under all register settings",
                 items_sent);
        $display("tb_top: %0d results checked, %0d string ends, %0d mismatches",
                 board.results_checked, board.ends_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
